@@ rtl/core/lzbd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzbd_pkg
// shared phase, status and width constants of the lz byte decompressor
// ----------------------------------------------------------------------------
package lzbd_pkg;

    localparam int unsigned SizeW = 24;

    localparam logic [3:0] PH_MODE    = 4'd0;
    localparam logic [3:0] PH_SZ0     = 4'd1;
    localparam logic [3:0] PH_SZ1     = 4'd2;
    localparam logic [3:0] PH_SZ2     = 4'd3;
    localparam logic [3:0] PH_CONTROL = 4'd4;
    localparam logic [3:0] PH_LITERAL = 4'd5;
    localparam logic [3:0] PH_DIST_A  = 4'd6;
    localparam logic [3:0] PH_DIST_B  = 4'd7;
    localparam logic [3:0] PH_DRAIN   = 4'd8;
    localparam logic [3:0] PH_COPY    = 4'd9;
    localparam logic [3:0] PH_FLUSH   = 4'd10;
    localparam logic [3:0] PH_STATUS  = 4'd11;

    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_SIZE     = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_BADDIST  = 3'd4;
    localparam logic [2:0] ST_OVERRUN  = 3'd5;

endpackage

@@ rtl/core/lz_byte_decompressor_unit.sv @@
// ----------------------------------------------------------------------------
// lz_byte_decompressor_unit
// streaming lz77 byte decompressor with a 64 KiB history memory
// ----------------------------------------------------------------------------
// a literal byte leaves as a one-byte request in the cycle after it is
//   taken; match bytes are packed up to PACK_BYTES to a request, gathered in
//   r_acc and sent through the output register once it is free; a status
//   request follows the last data
// throughput: one source byte per cycle while the output is free; a match holds
//   intake until its bytes are copied and sent, longer while the output is held
// reset: synchronous active low; control state clears, history is not cleared
//   (reads only ever touch bytes written by the current stream)
module lz_byte_decompressor_unit #(
    parameter int unsigned HISTORY_DEPTH = 65536,
    parameter int unsigned PACK_BYTES    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_out_count,
    output logic        o_out_last,
    output logic [2:0]  o_out_status
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned PW = $clog2(PACK_BYTES + 1);
    localparam int unsigned SW = lzbd_pkg::SizeW;

    // history memory, one write and one registered read per cycle
    logic [7:0]    r_hist [HISTORY_DEPTH];
    logic [7:0]    r_rd_data;
    logic          hist_we;
    logic [AW-1:0] hist_wa;
    logic [7:0]    hist_wd;
    logic [AW-1:0] hist_ra;

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_wa] <= hist_wd;
        end
        // a read of the entry being written returns the new byte
        if (hist_we && hist_wa == hist_ra) begin
            r_rd_data <= hist_wd;
        end else begin
            r_rd_data <= r_hist[hist_ra];
        end
    end

    // control and datapath registers
    logic [3:0]    r_phase, n_phase;
    logic [3:0]    r_after, n_after;     // phase after a pending status request
    logic [2:0]    r_status, n_status;
    logic [SW-1:0] r_expected;
    logic [SW-1:0] r_produced, n_produced;
    logic [SW-1:0] r_declared, n_declared;
    logic          r_short, n_short;
    logic [7:0]    r_lit_left, n_lit_left;
    logic [7:0]    r_ctrl, n_ctrl;
    logic [7:0]    r_dhi, n_dhi;
    logic [7:0]    r_copy_left, n_copy_left;
    logic          r_rd_pend, n_rd_pend;
    logic          r_last, n_last;       // in_last of the token being copied
    logic [63:0]   r_acc, n_acc;
    logic [PW-1:0] r_pn, n_pn;
    // output register
    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_obytes, n_obytes;
    logic [3:0]    r_ocount, n_ocount;
    logic          r_olast, n_olast;
    logic [2:0]    r_ostat, n_ostat;

    logic          out_free;
    logic          take;
    logic          pack_full;
    logic          byte_phase;
    logic [SW:0]   lit_end;
    logic [SW:0]   match_end;
    logic [16:0]   mdist;
    logic [7:0]    mlen;
    logic [AW-1:0] src_addr;

    assign out_free  = !r_ovalid || !i_stall;
    assign pack_full = (r_pn == PW'(PACK_BYTES));

    // phases that take a source byte
    always_comb begin
        byte_phase = 1'b0;
        unique case (r_phase) inside
            lzbd_pkg::PH_MODE, lzbd_pkg::PH_SZ0, lzbd_pkg::PH_SZ1, lzbd_pkg::PH_SZ2,
            lzbd_pkg::PH_CONTROL, lzbd_pkg::PH_LITERAL, lzbd_pkg::PH_DIST_A,
            lzbd_pkg::PH_DIST_B, lzbd_pkg::PH_DRAIN:
                byte_phase = 1'b1;
            lzbd_pkg::PH_COPY, lzbd_pkg::PH_FLUSH, lzbd_pkg::PH_STATUS:
                byte_phase = 1'b0;
            default:
                byte_phase = 1'b0;
        endcase
    end

    // intake only with an empty pack and room for one request this cycle
    assign o_stall = !(byte_phase && out_free && r_pn == '0);
    assign take    = i_valid && !o_stall;

    assign lit_end = {1'b0, r_produced} + {18'd0, i_in_byte[6:0]} + 25'd1;

    always_comb begin
        if (r_short) begin
            mdist = {6'd0, r_ctrl[2:0], i_in_byte} + 17'd1;
            mlen  = {4'd0, r_ctrl[6:3]} + 8'd3;
        end else begin
            mdist = {1'b0, r_dhi, i_in_byte} + 17'd1;
            mlen  = {1'b0, r_ctrl[6:0]} + 8'd4;
        end
    end
    assign match_end = {1'b0, r_produced} + {17'd0, mlen};
    assign src_addr  = AW'(r_produced - SW'(mdist));

    always_comb begin
        n_phase     = r_phase;
        n_after     = r_after;
        n_status    = r_status;
        n_produced  = r_produced;
        n_declared  = r_declared;
        n_short     = r_short;
        n_lit_left  = r_lit_left;
        n_ctrl      = r_ctrl;
        n_dhi       = r_dhi;
        n_copy_left = r_copy_left;
        n_rd_pend   = 1'b0;
        n_last      = r_last;
        n_acc       = r_acc;
        n_pn        = r_pn;
        n_ovalid    = r_ovalid && i_stall;
        n_obytes    = r_obytes;
        n_ocount    = r_ocount;
        n_olast     = r_olast;
        n_ostat     = r_ostat;
        hist_we     = 1'b0;
        hist_wa     = AW'(r_produced);
        hist_wd     = i_in_byte;
        hist_ra     = AW'(r_produced);

        // a full pack, or the rest of a match before the next byte, goes out
        // first whenever the output register is free
        if (out_free && (pack_full || (byte_phase && r_pn != '0))) begin
            n_ovalid = 1'b1;
            n_obytes = r_acc;
            n_ocount = 4'(r_pn);
            n_olast  = 1'b0;
            n_ostat  = lzbd_pkg::ST_DATA;
            n_acc    = '0;
            n_pn     = '0;
        end

        if (take) begin
            unique case (r_phase) inside
                lzbd_pkg::PH_DRAIN: begin
                    if (i_in_last) n_phase = lzbd_pkg::PH_MODE;
                end
                lzbd_pkg::PH_MODE: begin
                    n_short    = (i_in_byte == 8'd1);
                    n_produced = '0;
                    n_status   = lzbd_pkg::ST_TRUNC;
                    n_after    = lzbd_pkg::PH_MODE;
                    n_phase    = i_in_last ? lzbd_pkg::PH_FLUSH : lzbd_pkg::PH_SZ0;
                end
                lzbd_pkg::PH_SZ0: begin
                    n_declared = {i_in_byte, 16'd0};
                    n_status   = lzbd_pkg::ST_TRUNC;
                    n_after    = lzbd_pkg::PH_MODE;
                    n_phase    = i_in_last ? lzbd_pkg::PH_FLUSH : lzbd_pkg::PH_SZ1;
                end
                lzbd_pkg::PH_SZ1: begin
                    n_declared = {r_declared[23:16], i_in_byte, 8'd0};
                    n_status   = lzbd_pkg::ST_TRUNC;
                    n_after    = lzbd_pkg::PH_MODE;
                    n_phase    = i_in_last ? lzbd_pkg::PH_FLUSH : lzbd_pkg::PH_SZ2;
                end
                lzbd_pkg::PH_SZ2: begin
                    n_declared = {r_declared[23:8], i_in_byte};
                    n_after    = i_in_last ? lzbd_pkg::PH_MODE : lzbd_pkg::PH_DRAIN;
                    if (n_declared != r_expected) begin
                        n_status = lzbd_pkg::ST_SIZE;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end else if (n_declared == r_produced) begin
                        n_status = lzbd_pkg::ST_COMPLETE;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end else if (i_in_last) begin
                        n_status = lzbd_pkg::ST_TRUNC;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end else begin
                        n_phase  = lzbd_pkg::PH_CONTROL;
                    end
                end
                lzbd_pkg::PH_CONTROL: begin
                    n_ctrl  = i_in_byte;
                    n_after = i_in_last ? lzbd_pkg::PH_MODE : lzbd_pkg::PH_DRAIN;
                    if (!i_in_byte[7]) begin
                        if (lit_end > {1'b0, r_declared}) begin
                            n_status = lzbd_pkg::ST_OVERRUN;
                            n_phase  = lzbd_pkg::PH_FLUSH;
                        end else if (i_in_last) begin
                            n_status = lzbd_pkg::ST_TRUNC;
                            n_phase  = lzbd_pkg::PH_FLUSH;
                        end else begin
                            n_lit_left = {1'b0, i_in_byte[6:0]} + 8'd1;
                            n_phase    = lzbd_pkg::PH_LITERAL;
                        end
                    end else if (i_in_last) begin
                        n_status = lzbd_pkg::ST_TRUNC;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end else begin
                        n_phase = lzbd_pkg::PH_DIST_A;
                    end
                end
                lzbd_pkg::PH_LITERAL: begin
                    // each literal byte is a request of its own
                    hist_we    = 1'b1;
                    n_produced = r_produced + SW'(1);
                    n_ovalid   = 1'b1;
                    n_obytes   = 64'(i_in_byte);
                    n_ocount   = 4'd1;
                    n_olast    = 1'b0;
                    n_ostat    = lzbd_pkg::ST_DATA;
                    n_lit_left = r_lit_left - 8'd1;
                    n_after    = i_in_last ? lzbd_pkg::PH_MODE : lzbd_pkg::PH_DRAIN;
                    if (n_lit_left == 8'd0) begin
                        if (n_produced == r_declared) begin
                            n_status = lzbd_pkg::ST_COMPLETE;
                            n_phase  = lzbd_pkg::PH_FLUSH;
                        end else if (i_in_last) begin
                            n_status = lzbd_pkg::ST_TRUNC;
                            n_phase  = lzbd_pkg::PH_FLUSH;
                        end else begin
                            n_phase = lzbd_pkg::PH_CONTROL;
                        end
                    end else if (i_in_last) begin
                        n_status = lzbd_pkg::ST_TRUNC;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end
                end
                lzbd_pkg::PH_DIST_A, lzbd_pkg::PH_DIST_B: begin
                    n_after = i_in_last ? lzbd_pkg::PH_MODE : lzbd_pkg::PH_DRAIN;
                    n_last  = i_in_last;
                    if (r_phase == lzbd_pkg::PH_DIST_A && !r_short) begin
                        n_dhi    = i_in_byte;
                        n_status = lzbd_pkg::ST_TRUNC;
                        n_phase  = i_in_last ? lzbd_pkg::PH_FLUSH : lzbd_pkg::PH_DIST_B;
                    end else if ({8'd0, mdist} > {1'b0, r_produced}) begin
                        n_status = lzbd_pkg::ST_BADDIST;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end else if (match_end > {1'b0, r_declared}) begin
                        n_status = lzbd_pkg::ST_OVERRUN;
                        n_phase  = lzbd_pkg::PH_FLUSH;
                    end else begin
                        // first source read; each copied byte reads the next
                        hist_ra     = src_addr;
                        n_rd_pend   = 1'b1;
                        n_ctrl      = 8'(mdist[7:0]);
                        n_dhi       = 8'(mdist[15:8]);
                        n_copy_left = mlen;
                        n_phase     = lzbd_pkg::PH_COPY;
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (r_phase)
                lzbd_pkg::PH_COPY: begin
                    // distance sits in r_dhi:r_ctrl (max 0x10000 wraps to 0 in those 16 bits)
                    if (r_rd_pend && !pack_full) begin
                        hist_we     = 1'b1;
                        hist_wd     = r_rd_data;
                        n_produced  = r_produced + SW'(1);
                        n_acc       = r_acc | (64'(r_rd_data) << {r_pn, 3'b000});
                        n_pn        = r_pn + PW'(1);
                        n_copy_left = r_copy_left - 8'd1;
                        if (n_copy_left == 8'd0) begin
                            if (n_produced == r_declared) begin
                                n_status = lzbd_pkg::ST_COMPLETE;
                                n_phase  = lzbd_pkg::PH_FLUSH;
                            end else if (r_last) begin
                                n_status = lzbd_pkg::ST_TRUNC;
                                n_phase  = lzbd_pkg::PH_FLUSH;
                            end else begin
                                n_phase = lzbd_pkg::PH_CONTROL;
                            end
                        end else begin
                            hist_ra   = AW'(n_produced - SW'({r_dhi, r_ctrl}));
                            n_rd_pend = 1'b1;
                        end
                    end else if (r_rd_pend) begin
                        // hold the read while the pack drains
                        hist_ra   = AW'(r_produced - SW'({r_dhi, r_ctrl}));
                        n_rd_pend = 1'b1;
                    end
                end
                lzbd_pkg::PH_FLUSH: begin
                    // emit any partial pack, then the status request
                    if (out_free && !pack_full) begin
                        if (r_pn != '0) begin
                            n_ovalid = 1'b1;
                            n_obytes = r_acc;
                            n_ocount = 4'(r_pn);
                            n_olast  = 1'b0;
                            n_ostat  = lzbd_pkg::ST_DATA;
                            n_acc    = '0;
                            n_pn     = '0;
                            n_phase  = lzbd_pkg::PH_STATUS;
                        end else begin
                            n_ovalid = 1'b1;
                            n_obytes = '0;
                            n_ocount = '0;
                            n_olast  = 1'b1;
                            n_ostat  = r_status;
                            n_phase  = r_after;
                        end
                    end
                end
                lzbd_pkg::PH_STATUS: begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_obytes = '0;
                        n_ocount = '0;
                        n_olast  = 1'b1;
                        n_ostat  = r_status;
                        n_phase  = r_after;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lzbd_pkg::PH_MODE;
            r_after    <= lzbd_pkg::PH_MODE;
            r_status   <= lzbd_pkg::ST_DATA;
            r_expected <= '0;
            r_produced <= '0;
            r_declared <= '0;
            r_short    <= 1'b0;
            r_lit_left <= '0;
            r_rd_pend  <= 1'b0;
            r_pn       <= '0;
            r_acc      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_expected <= i_cfg_wdata;
            r_phase    <= n_phase;
            r_after    <= n_after;
            r_status   <= n_status;
            r_produced <= n_produced;
            r_declared <= n_declared;
            r_short    <= n_short;
            r_lit_left <= n_lit_left;
            r_rd_pend  <= n_rd_pend;
            r_pn       <= n_pn;
            r_acc      <= n_acc;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl      <= n_ctrl;
        r_dhi       <= n_dhi;
        r_copy_left <= n_copy_left;
        r_last      <= n_last;
        r_obytes    <= n_obytes;
        r_ocount    <= n_ocount;
        r_olast     <= n_olast;
        r_ostat     <= n_ostat;
    end

    assign o_valid      = r_ovalid;
    assign o_out_bytes  = r_obytes;
    assign o_out_count  = r_ocount;
    assign o_out_last   = r_olast;
    assign o_out_status = r_ostat;

endmodule

@@ bench/lzbd_checker.sv @@
// ----------------------------------------------------------------------------
// lzbd_checker
// watches both channels of the lz byte decompressor, predicts every packed
// result from the accepted source bytes and compares field by field
// ----------------------------------------------------------------------------
module lzbd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_stall_out,
    input  logic [63:0] i_out_bytes,
    input  logic [3:0]  i_out_count,
    input  logic        i_out_last,
    input  logic [2:0]  i_out_status,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic [2:0]  status;
    } t_pack;

    t_pack       want_q[$];
    logic [7:0]  hist_mem [0:65535];
    logic [23:0] n_out;
    logic [23:0] n_decl;
    logic [23:0] size_reg;
    logic [3:0]  ph;
    logic        short_fmt;
    logic [7:0]  lit_left;
    logic [7:0]  ctl_byte;
    logic [7:0]  dist_hi;
    logic [63:0] acc;
    int          acc_n;
    logic        cur_last;
    int          fails;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("%0t lzbd error: %s got %0h want %0h", $realtime, what, got, exp);
        fails++;
    endtask

    task automatic push_pack(input logic [63:0] b, input logic [3:0] c,
                             input logic l, input logic [2:0] s);
        t_pack p;
        p.bytes = b; p.count = c; p.last = l; p.status = s;
        want_q.insert(want_q.size(), p);
    endtask

    task automatic flush_pack();
        if (acc_n > 0) push_pack(acc, 4'(acc_n), 1'b0, lzbd_pkg::ST_DATA);
        acc = '0;
        acc_n = 0;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        hist_mem[n_out[15:0]] = b;
        n_out = n_out + 24'd1;
        acc = acc | (64'(b) << (8 * acc_n));
        acc_n++;
        if (acc_n >= 8) flush_pack();
    endtask

    task automatic end_stream(input logic [2:0] s);
        flush_pack();
        push_pack('0, 4'd0, 1'b1, s);
        ph = cur_last ? lzbd_pkg::PH_MODE : lzbd_pkg::PH_DRAIN;
    endtask

    task automatic token_done();
        if (n_out == n_decl) end_stream(lzbd_pkg::ST_COMPLETE);
        else if (cur_last) end_stream(lzbd_pkg::ST_TRUNC);
        else ph = lzbd_pkg::PH_CONTROL;
    endtask

    task automatic copy_match(input int mdist, input int len);
        logic [7:0] b;
        if (mdist > int'(n_out)) begin
            end_stream(lzbd_pkg::ST_BADDIST);
            return;
        end
        if (int'(n_out) + len > int'(n_decl)) begin
            end_stream(lzbd_pkg::ST_OVERRUN);
            return;
        end
        for (int i = 0; i < len; i++) begin
            b = hist_mem[16'(n_out - 24'(mdist))];
            emit_byte(b);
        end
        token_done();
    endtask

    // one accepted source byte
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        int n;
        cur_last = lst;
        acc = '0;
        acc_n = 0;
        case (ph)
            lzbd_pkg::PH_DRAIN: if (lst) ph = lzbd_pkg::PH_MODE;
            lzbd_pkg::PH_MODE: begin
                short_fmt = (b == 8'd1);
                n_out = '0;
                if (lst) end_stream(lzbd_pkg::ST_TRUNC); else ph = lzbd_pkg::PH_SZ0;
            end
            lzbd_pkg::PH_SZ0: begin
                n_decl = {b, 16'h0};
                if (lst) end_stream(lzbd_pkg::ST_TRUNC); else ph = lzbd_pkg::PH_SZ1;
            end
            lzbd_pkg::PH_SZ1: begin
                n_decl[15:8] = b;
                if (lst) end_stream(lzbd_pkg::ST_TRUNC); else ph = lzbd_pkg::PH_SZ2;
            end
            lzbd_pkg::PH_SZ2: begin
                n_decl[7:0] = b;
                if (n_decl != size_reg) end_stream(lzbd_pkg::ST_SIZE);
                else token_done();
            end
            lzbd_pkg::PH_CONTROL: begin
                ctl_byte = b;
                if (!b[7]) begin
                    n = int'(b[6:0]) + 1;
                    if (int'(n_out) + n > int'(n_decl)) end_stream(lzbd_pkg::ST_OVERRUN);
                    else if (lst) end_stream(lzbd_pkg::ST_TRUNC);
                    else begin
                        lit_left = 8'(n);
                        ph = lzbd_pkg::PH_LITERAL;
                    end
                end else if (lst) end_stream(lzbd_pkg::ST_TRUNC);
                else ph = lzbd_pkg::PH_DIST_A;
            end
            lzbd_pkg::PH_LITERAL: begin
                emit_byte(b);
                lit_left = lit_left - 8'd1;
                if (lit_left == 0) token_done();
                else if (lst) end_stream(lzbd_pkg::ST_TRUNC);
            end
            lzbd_pkg::PH_DIST_A: begin
                if (short_fmt) begin
                    copy_match(int'({ctl_byte[2:0], b}) + 1, int'(ctl_byte[6:3]) + 3);
                end else begin
                    dist_hi = b;
                    if (lst) end_stream(lzbd_pkg::ST_TRUNC); else ph = lzbd_pkg::PH_DIST_B;
                end
            end
            lzbd_pkg::PH_DIST_B:
                copy_match(int'({dist_hi, b}) + 1, int'(ctl_byte[6:0]) + 4);
            default: ph = lst ? lzbd_pkg::PH_MODE : lzbd_pkg::PH_DRAIN;
        endcase
        flush_pack();
    endtask

    always @(posedge i_clk) begin
        t_pack w;
        if (!i_rst_n) begin
            want_q.delete();
            n_out = '0; n_decl = '0; size_reg = '0; ph = lzbd_pkg::PH_MODE;
            short_fmt = 1'b0; lit_left = '0; ctl_byte = '0; dist_hi = '0;
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_valid && !i_stall_in) decode_byte(i_in_byte, i_in_last);
            if (i_out_valid && !i_stall_out) begin
                if (want_q.size() == 0) begin
                    report("unexpected result", i_out_bytes, 64'd0);
                end else begin
                    w = want_q.pop_front();
                    if (i_out_bytes !== w.bytes) report("bytes", i_out_bytes, w.bytes);
                    if (i_out_count !== w.count) report("count", 64'(i_out_count), 64'(w.count));
                    if (i_out_last !== w.last) report("last", 64'(i_out_last), 64'(w.last));
                    if (i_out_status !== w.status)
                        report("status", 64'(i_out_status), 64'(w.status));
                end
            end
        end
        o_pending <= want_q.size();
        o_fail_count <= fails;
    end

    initial fails = 0;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus for the lz byte decompressor: compressed streams of both formats,
// clean and broken, under random idling and one long output hold
// ----------------------------------------------------------------------------
module tb;

    // which way a generated stream goes wrong
    typedef enum int { FL_NONE, FL_TRUNC, FL_BADDIST, FL_OVERRUN, FL_SIZE } t_flaw;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [23:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_out_bytes;
    logic [3:0]  o_out_count;
    logic        o_out_last;
    logic [2:0]  o_out_status;

    int          fail_count;
    int          pending;
    int          sent;
    logic [23:0] cur_size;
    bit          quiet;
    bit          hold_req;
    logic [8:0]  src_q[$];   // {last, byte}

    lz_byte_decompressor_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_bytes  (o_out_bytes),
        .o_out_count  (o_out_count),
        .o_out_last   (o_out_last),
        .o_out_status (o_out_status)
    );

    lzbd_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_out_valid  (o_valid),
        .i_stall_out  (i_stall),
        .i_out_bytes  (o_out_bytes),
        .i_out_count  (o_out_count),
        .i_out_last   (o_out_last),
        .i_out_status (o_out_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #20000000;
        $display("lz_byte_decompressor_unit: mismatch");
        $finish;
    end

    // output side: random stall bursts, one long hold while requests keep coming
    initial begin
        bit held;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic int min2(input int a, input int b);
        return a < b ? a : b;
    endfunction

    function automatic void put(input logic [7:0] b);
        src_q.insert(src_q.size(), {1'b0, b});
    endfunction

    // builds one compressed stream for the current expected size
    function automatic void build_stream(input t_flaw flaw);
        int    sz, p, lim, rem, n, len, d, k;
        logic [7:0] mode;
        logic [23:0] decl;
        src_q.delete();
        sz = int'(cur_size);
        mode = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'($urandom_range(0, 255));
        decl = cur_size;
        if (flaw == FL_SIZE) decl = cur_size ^ 24'(1 << $urandom_range(0, 23));
        put(mode);
        put(decl[23:16]);
        put(decl[15:8]);
        put(decl[7:0]);
        p = 0;
        lim = (flaw == FL_NONE || flaw == FL_SIZE) ? sz : min2(sz, $urandom_range(0, 60));
        if (flaw == FL_TRUNC && sz > 0) lim = $urandom_range(0, min2(sz - 1, 60));
        if (flaw != FL_SIZE) begin
            while (p < lim) begin
                rem = sz - p;
                if (p > 0 && rem >= 4 && $urandom_range(0, 1) != 0) begin
                    if (mode == 8'd1) begin
                        len = $urandom_range(3, min2(18, rem));
                        d = ($urandom_range(0, 3) == 0) ? min2(p, 2048)
                                                          : $urandom_range(1, min2(p, 2048));
                        put(8'h80 | 8'((len - 3) << 3) | 8'((d - 1) >> 8));
                        put(8'(d - 1));
                    end else begin
                        len = $urandom_range(4, min2(131, rem));
                        d = $urandom_range(1, min2(p, 65536));
                        put(8'h80 | 8'(len - 4));
                        put(8'((d - 1) >> 8));
                        put(8'(d - 1));
                    end
                    p += len;
                end else begin
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 12);
                    n = min2(n, rem);
                    put(8'(n - 1));
                    repeat (n) put(8'($urandom_range(0, 255)));
                    p += n;
                end
            end
        end
        if (flaw == FL_BADDIST) begin
            // reach back past the start of the output
            d = p + $urandom_range(1, 8);
            if (mode == 8'd1) begin
                put(8'h80 | 8'($urandom_range(0, 15) << 3) | 8'((d - 1) >> 8));
                put(8'(d - 1));
            end else begin
                put(8'h80 | 8'($urandom_range(0, 127)));
                put(8'((d - 1) >> 8));
                put(8'(d - 1));
            end
        end else if (flaw == FL_OVERRUN) begin
            rem = sz - p;
            if (rem < 128 && $urandom_range(0, 1) != 0) begin
                put(8'($urandom_range(rem, 127)));
            end else if (mode == 8'd1) begin
                put(8'h80 | 8'(15 << 3));
                put(8'(min2(p, 1) == 0 ? 0 : $urandom_range(0, min2(p, 2048) - 1)));
            end else begin
                put(8'h80 | 8'h7f);
                put(8'h00);
                put(8'h00);
            end
        end
        if (flaw == FL_TRUNC) begin
            k = $urandom_range(0, src_q.size() - 1);
            while (src_q.size() > k + 1) void'(src_q.pop_back());
        end else if (flaw != FL_NONE) begin
            // bytes after the error are dropped up to the end mark
            repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
            put(8'($urandom_range(0, 255)));
        end
        src_q[src_q.size() - 1][8] = 1'b1;
    endfunction

    // offers the built stream, one request per byte
    task automatic send_stream();
        foreach (src_q[i]) begin
            if (!quiet && $urandom_range(0, 6) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_in_byte <= src_q[i][7:0];
            i_in_last <= src_q[i][8];
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            sent++;
            if (sent == 150) hold_req = 1'b1;
        end
        i_valid <= 1'b0;
    endtask

    // register write only once the block has gone quiet
    task automatic set_size(input logic [23:0] v);
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cur_size = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_flaw f;
        int    r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_in_byte = '0;
        i_in_last = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        cur_size = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty output, a header size fault, then errors on a tiny size
        set_size(24'd0);
        build_stream(FL_NONE);    send_stream();
        build_stream(FL_SIZE);    send_stream();
        set_size(24'd10);
        build_stream(FL_BADDIST); send_stream();
        build_stream(FL_OVERRUN); send_stream();
        build_stream(FL_TRUNC);   send_stream();
        // all-ones size, cut short long before it could complete
        set_size(24'hffffff);
        build_stream(FL_TRUNC);   send_stream();

        // random streams, mostly well formed
        while (sent < 470) begin
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 9);
                set_size(r == 0 ? 24'd0 : r < 8 ? 24'($urandom_range(1, 80))
                                               : 24'($urandom_range(81, 300)));
            end
            if (sent > 400) quiet = 1'b1;
            r = $urandom_range(0, 9);
            f = (r < 6) ? FL_NONE : (r == 6) ? FL_TRUNC : (r == 7) ? FL_BADDIST
              : (r == 8) ? FL_OVERRUN : FL_SIZE;
            if (cur_size == 24'hffffff) f = FL_TRUNC;
            build_stream(f);
            send_stream();
        end

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("lz_byte_decompressor_unit: match");
        end else begin
            $display("lz_byte_decompressor_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lzbd_pkg.sv
rtl/core/lz_byte_decompressor_unit.sv
bench/lzbd_checker.sv
bench/tb.sv
